// ----- sv/pcp_pkg.sv -----
`default_nettype none

package pcp_pkg;

  // register and field widths
  localparam int LIMIT_W     = 16;
  localparam int GAIN_W      = 15;
  localparam int CFG_DATA_W  = 16;
  localparam int REG_INDEX_W = 2;
  localparam int COLOR_W     = 28;

  // register map
  typedef enum logic [REG_INDEX_W-1:0] {
    REG_LIMIT = 2'd0,
    REG_RED   = 2'd1,
    REG_GREEN = 2'd2,
    REG_BLUE  = 2'd3
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd64;
  localparam logic [GAIN_W-1:0]  RED_RESET   = 15'd2304;
  localparam logic [GAIN_W-1:0]  GREEN_RESET = 15'd3840;
  localparam logic [GAIN_W-1:0]  BLUE_RESET  = 15'd2176;

  // position t in Q0.16, divider split
  localparam int Q_BITS             = 16;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = Q_BITS / DIV_BITS_PER_STAGE;

  // datapath widths
  localparam int PROD_W    = 2 * Q_BITS;        // u*t, t*t, u*u
  localparam int MONO_W    = 2 * PROD_W;        // u^a * t^b, four factors
  localparam int HALF_W    = MONO_W / 2;
  localparam int KW        = GAIN_W + 8;        // gain * 255
  localparam int PP_W      = HALF_W + KW;
  localparam int ACC_W     = MONO_W + KW;
  localparam int DROP_BITS = 72;
  localparam int CH_W      = ACC_W - DROP_BITS;

  // channels and packing
  localparam int NUM_CH    = 3;
  localparam int CH_RED    = 0;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 2;
  localparam int RED_POS   = 16;
  localparam int GREEN_POS = 8;

  typedef struct packed {
    logic [Q_BITS-1:0] t;
    logic              zero;   // t is 0 or 1.0: every channel is zero
  } pos_t;

  typedef struct packed {
    logic [NUM_CH-1:0][MONO_W-1:0] m;
    logic                          zero;
  } mono_t;

  typedef struct packed {
    logic [NUM_CH-1:0][GAIN_W-1:0] g;
  } gains_t;

endpackage

`default_nettype wire

// ----- sv/pcp_divider.sv -----
`default_nettype none

module pcp_divider #(
  parameter int INDEX_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [INDEX_BITS-1:0]        index,
  input  logic [pcp_pkg::LIMIT_W-1:0]  limit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pcp_pkg::pos_t                pos
);
  import pcp_pkg::*;

  localparam int CMP_W = (INDEX_BITS > LIMIT_W) ? INDEX_BITS : LIMIT_W;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [Q_BITS:0] div_step(input logic [Q_BITS-1:0] rem_in,
                                               input logic [LIMIT_W-1:0] lim);
    logic [Q_BITS:0] r2;
    logic [Q_BITS:0] diff;
    r2   = {rem_in, 1'b0};
    diff = r2 - {1'b0, lim};
    if (r2 >= {1'b0, lim}) begin
      div_step = {1'b1, diff[Q_BITS-1:0]};
    end else begin
      div_step = {1'b0, r2[Q_BITS-1:0]};
    end
  endfunction

  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  lim_ext;
  logic              in_sat;
  logic [Q_BITS-1:0] init_rem;

  logic              v    [DIV_STAGES];
  logic              sat  [DIV_STAGES];
  logic [Q_BITS-1:0] rem  [DIV_STAGES];
  logic [Q_BITS-1:0] quo  [DIV_STAGES];
  logic              rdy  [DIV_STAGES+1];

  // index >= limit (or limit zero) saturates t at 1.0; otherwise the
  // remainder starts below the limit and 16 steps give the quotient
  assign idx_ext  = CMP_W'(index);
  assign lim_ext  = CMP_W'(limit);
  assign in_sat   = (limit == '0) || (idx_ext >= lim_ext);
  assign init_rem = in_sat ? '0 : idx_ext[Q_BITS-1:0];

  assign rdy[DIV_STAGES] = out_ready;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic              src_valid;
    logic              src_sat;
    logic [Q_BITS-1:0] src_rem;
    logic [Q_BITS-1:0] src_quo;
    logic [Q_BITS-1:0] rem_next;
    logic [Q_BITS-1:0] quo_next;

    if (g == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_sat   = in_sat;
      assign src_rem   = init_rem;
      assign src_quo   = '0;
    end else begin : g_rest
      assign src_valid = v[g-1];
      assign src_sat   = sat[g-1];
      assign src_rem   = rem[g-1];
      assign src_quo   = quo[g-1];
    end

    assign rdy[g] = !v[g] || rdy[g+1];

    always_comb begin
      logic [Q_BITS:0] step;
      rem_next = src_rem;
      quo_next = src_quo;
      for (int s = 0; s < DIV_BITS_PER_STAGE; s++) begin
        step     = div_step(rem_next, limit);
        rem_next = step[Q_BITS-1:0];
        quo_next = {quo_next[Q_BITS-2:0], step[Q_BITS]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (rdy[g]) begin
        v[g] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        rem[g] <= rem_next;
        quo[g] <= quo_next;
        sat[g] <= src_sat;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[DIV_STAGES-1];
  assign pos.t     = quo[DIV_STAGES-1];
  assign pos.zero  = sat[DIV_STAGES-1] || (quo[DIV_STAGES-1] == '0);

endmodule

`default_nettype wire

// ----- sv/pcp_power.sv -----
`default_nettype none

module pcp_power (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcp_pkg::pos_t  pos,
  output logic           out_valid,
  input  logic           out_ready,
  output pcp_pkg::mono_t mono
);
  import pcp_pkg::*;

  logic              a_valid;
  logic              b_valid;
  logic              a_ready;
  logic              b_ready;
  logic [Q_BITS-1:0] u_in;
  logic [PROD_W-1:0] ut;
  logic [PROD_W-1:0] t2;
  logic [PROD_W-1:0] u2;
  logic              a_zero;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // u = 1.0 - t; t of zero or 1.0 is flagged, so 16 bits suffice
  assign u_in = ~pos.t + Q_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  // first stage: the two 16x16 squares and the cross product
  always_ff @(posedge clk) begin
    if (a_ready) begin
      ut     <= PROD_W'(u_in) * PROD_W'(pos.t);
      t2     <= PROD_W'(pos.t) * PROD_W'(pos.t);
      u2     <= PROD_W'(u_in) * PROD_W'(u_in);
      a_zero <= pos.zero;
    end
  end

  // second stage: u*t^3, u^2*t^2, u^3*t as 32x32 products
  always_ff @(posedge clk) begin
    if (b_ready) begin
      mono.m[CH_RED]   <= MONO_W'(ut) * MONO_W'(t2);
      mono.m[CH_GREEN] <= MONO_W'(u2) * MONO_W'(t2);
      mono.m[CH_BLUE]  <= MONO_W'(u2) * MONO_W'(ut);
      mono.zero        <= a_zero;
    end
  end

  assign out_valid = b_valid;

endmodule

`default_nettype wire

// ----- sv/pcp_scale.sv -----
`default_nettype none

module pcp_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pcp_pkg::mono_t               mono,
  input  pcp_pkg::gains_t              gains,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcp_pkg::COLOR_W-1:0]  color
);
  import pcp_pkg::*;

  logic                 d_valid;
  logic                 e_valid;
  logic                 d_ready;
  logic                 e_ready;
  logic [KW-1:0]        k     [NUM_CH];
  logic [PP_W-1:0]      lo    [NUM_CH];
  logic [PP_W-1:0]      hi    [NUM_CH];
  logic                 d_zero;
  logic [ACC_W-1:0]     full  [NUM_CH];
  logic [CH_W-1:0]      ch    [NUM_CH];
  logic [COLOR_W-1:0]   color_next;

  assign e_ready  = !e_valid || out_ready;
  assign d_ready  = !d_valid || e_ready;
  assign in_ready = d_ready;

  // gain * 255 as shift and subtract
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    assign k[c]    = KW'({gains.g[c], 8'b0}) - KW'(gains.g[c]);
    assign full[c] = {hi[c], {HALF_W{1'b0}}} + ACC_W'(lo[c]);
    assign ch[c]   = full[c][ACC_W-1 -: CH_W];
  end

  // channels overlap in the OR; bits above the word are dropped
  assign color_next = (COLOR_W'(ch[CH_RED]) << RED_POS)
                    | (COLOR_W'(ch[CH_GREEN]) << GREEN_POS)
                    | COLOR_W'(ch[CH_BLUE]);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (d_ready) begin
        d_valid <= in_valid;
      end
      if (e_ready) begin
        e_valid <= d_valid;
      end
    end
  end

  // split each 64-bit monomial into halves times the 23-bit gain
  always_ff @(posedge clk) begin
    if (d_ready) begin
      for (int c = 0; c < NUM_CH; c++) begin
        lo[c] <= PP_W'(mono.m[c][HALF_W-1:0]) * PP_W'(k[c]);
        hi[c] <= PP_W'(mono.m[c][MONO_W-1:HALF_W]) * PP_W'(k[c]);
      end
      d_zero <= mono.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) begin
      color <= d_zero ? '0 : color_next;
    end
  end

  assign out_valid = e_valid;

endmodule

`default_nettype wire

// ----- sv/polynomial_color_palette.sv -----
`default_nettype none

// Channel    Signals                          Word
// ---------  -------------------------------  ---------------------------------
// input      in_valid / in_ready              index, INDEX_BITS unsigned
// output     out_valid / out_ready            color, 28 bits packed RGB
// config     cfg_we, cfg_index, cfg_data      limit, red, green, blue gains
//
// Throughput is one word per cycle while the output does not stall.
// The divider for t takes 8 stages (two quotient bits each), the power
// products 2 stages, gain scaling and packing 2 more.
// Reset clears the valid bits of every stage and loads the register defaults.
// Each stage holds only while its successor is full, so bubbles close up and
// a stalled output does not block input until the pipe is full.

module polynomial_color_palette #(
  parameter int INDEX_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [INDEX_BITS-1:0]              index,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pcp_pkg::COLOR_W-1:0]        color,
  // register writes
  input  logic                               cfg_we,
  input  logic [pcp_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  logic [pcp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pcp_pkg::*;

  logic [LIMIT_W-1:0] iteration_limit;
  logic [GAIN_W-1:0]  red_gain;
  logic [GAIN_W-1:0]  green_gain;
  logic [GAIN_W-1:0]  blue_gain;
  gains_t             gains;

  logic               div_valid;
  logic               div_ready;
  pos_t               pos;
  logic               pow_valid;
  logic               pow_ready;
  mono_t              mono;

  // config registers; the user must write them only while the pipe is empty (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RESET;
      red_gain        <= RED_RESET;
      green_gain      <= GREEN_RESET;
      blue_gain       <= BLUE_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LIMIT: iteration_limit <= cfg_data[LIMIT_W-1:0];
        REG_RED:   red_gain        <= cfg_data[GAIN_W-1:0];
        REG_GREEN: green_gain      <= cfg_data[GAIN_W-1:0];
        REG_BLUE:  blue_gain       <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign gains.g[CH_RED]   = red_gain;
  assign gains.g[CH_GREEN] = green_gain;
  assign gains.g[CH_BLUE]  = blue_gain;

  // t = floor(index * 2^16 / limit), saturated at 1.0
  pcp_divider #(
    .INDEX_BITS (INDEX_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .index     (index),
    .limit     (iteration_limit),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .pos       (pos)
  );

  // u*t^3, u^2*t^2, u^3*t
  pcp_power u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .pos       (pos),
    .out_valid (pow_valid),
    .out_ready (pow_ready),
    .mono      (mono)
  );

  // times gain*255, drop 72 fraction bits, pack into the color word
  pcp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pow_valid),
    .in_ready  (pow_ready),
    .mono      (mono),
    .gains     (gains),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .color     (color)
  );

endmodule

`default_nettype wire
